[sv/interval_overlap_roc_counter_defines.svh]
// assertion macros shared by the checker of interval_overlap_roc_counter
// needs clk and rst in the scope where a macro is used
`ifndef INTERVAL_OVERLAP_ROC_COUNTER_DEFINES_SVH
`define INTERVAL_OVERLAP_ROC_COUNTER_DEFINES_SVH

// same-cycle implication
`define IOROC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IOROC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ioroc_pkg.sv]
// shared types and codes for the interval overlap roc counter
// no dependencies
package ioroc_pkg;

  localparam logic [1:0] CMD_LOAD          = 2'd0;
  localparam logic [1:0] CMD_CHECK         = 2'd1;
  localparam logic [1:0] CMD_END_FILE      = 2'd2;
  localparam logic [1:0] CMD_END_THRESHOLD = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CHECK,
    OP_END_FILE,
    OP_END_THRESHOLD
  } op_t;

  // status of the queue head as seen by the back end
  typedef struct packed {
    logic avail;
    op_t  op;
  } q_head_t;

endpackage

[sv/ioroc_front.sv]
// front end: accepts requests, decodes the command, holds them in a two-entry queue
// depends on ioroc_pkg
module ioroc_front #(
  parameter int POS_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic [POS_BITS-1:0]   interval_begin,
  input  logic [POS_BITS-1:0]   interval_end,
  output ioroc_pkg::q_head_t    head,
  output logic [POS_BITS-1:0]   head_begin,
  output logic [POS_BITS-1:0]   head_end,
  input  logic                  pop
);

  ioroc_pkg::op_t        op_q   [2];
  logic [POS_BITS-1:0]   beg_q  [2];
  logic [POS_BITS-1:0]   end_q  [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  ioroc_pkg::op_t        op_dec;
  logic                  push;

  always_comb begin
    unique case (cmd)
      ioroc_pkg::CMD_LOAD:     op_dec = ioroc_pkg::OP_LOAD;
      ioroc_pkg::CMD_CHECK:    op_dec = ioroc_pkg::OP_CHECK;
      ioroc_pkg::CMD_END_FILE: op_dec = ioroc_pkg::OP_END_FILE;
      default:                 op_dec = ioroc_pkg::OP_END_THRESHOLD;
    endcase
  end

  assign in_stall   = (fill == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.avail = (fill != 2'd0);
  assign head.op    = op_q[rd_ptr];
  assign head_begin = beg_q[rd_ptr];
  assign head_end   = end_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        op_q[wr_ptr]  <= op_dec;
        beg_q[wr_ptr] <= interval_begin;
        end_q[wr_ptr] <= interval_end;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[sv/ioroc_back.sv]
// back end: window table, scan sequencer, saturating counters and result register
// depends on ioroc_pkg
module ioroc_back #(
  parameter int MAX_WINDOWS = 256,
  parameter int POS_BITS    = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ioroc_pkg::q_head_t                 head,
  input  logic [POS_BITS-1:0]                head_begin,
  input  logic [POS_BITS-1:0]                head_end,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               slice_hit,
  output logic                               table_full,
  output logic [COUNT_BITS-1:0]              true_positives,
  output logic [COUNT_BITS-1:0]              false_positives,
  output logic [COUNT_BITS-1:0]              false_negatives,
  output logic [$clog2(MAX_WINDOWS+1)-1:0]   windows_stored
);

  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  logic [POS_BITS-1:0]   win_begin_mem [MAX_WINDOWS];
  logic [POS_BITS-1:0]   win_end_mem   [MAX_WINDOWS];
  logic                  mark_mem      [MAX_WINDOWS];

  state_t                state;
  logic [CNT_W-1:0]      stored_count;
  logic [COUNT_BITS-1:0] tp_total;
  logic [COUNT_BITS-1:0] fp_total;
  logic [COUNT_BITS-1:0] fn_total;
  ioroc_pkg::op_t        cur_op;
  logic [POS_BITS-1:0]   cur_begin;
  logic [POS_BITS-1:0]   cur_end;
  logic                  hit;
  logic [CNT_W-1:0]      issue_idx;
  logic                  rd_vld;
  logic                  rd_last;
  logic [IDX_W-1:0]      rd_idx;
  logic [POS_BITS-1:0]   win_rd_begin;
  logic [POS_BITS-1:0]   win_rd_end;
  logic                  mark_rd;

  logic                  out_free;
  logic                  res_load;
  logic                  tbl_full_now;
  logic                  do_load;
  logic                  do_eot;
  logic                  start_scan;
  logic                  issue;
  logic                  overlap;
  logic                  mark_set;
  logic                  mark_we;
  logic [IDX_W-1:0]      mark_wa;
  logic                  mark_wd;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  assign out_free     = !out_valid || !out_stall;
  assign tbl_full_now = (stored_count == CNT_W'(MAX_WINDOWS));
  assign do_load      = (state == S_IDLE) && head.avail && (head.op == ioroc_pkg::OP_LOAD)
                        && out_free;
  assign do_eot       = (state == S_IDLE) && head.avail
                        && (head.op == ioroc_pkg::OP_END_THRESHOLD) && out_free;
  assign start_scan   = (state == S_IDLE) && head.avail
                        && ((head.op == ioroc_pkg::OP_CHECK)
                            || (head.op == ioroc_pkg::OP_END_FILE));
  assign res_load     = do_load || do_eot || ((state == S_FINISH) && out_free);
  assign pop          = do_load || do_eot || start_scan;
  assign issue        = (state == S_SCAN) && (issue_idx != stored_count);
  assign overlap      = (win_rd_begin < cur_end) && (cur_begin < win_rd_end);
  assign mark_set     = (state == S_SCAN) && rd_vld && (cur_op == ioroc_pkg::OP_CHECK)
                        && overlap;

  // a new window starts unmarked, a hit during a check sets the mark
  assign mark_we = (do_load && !tbl_full_now) || mark_set;
  assign mark_wa = mark_set ? rd_idx : stored_count[IDX_W-1:0];
  assign mark_wd = mark_set;

  always_ff @(posedge clk) begin
    if (do_load && !tbl_full_now) begin
      win_begin_mem[stored_count[IDX_W-1:0]] <= head_begin;
      win_end_mem[stored_count[IDX_W-1:0]]   <= head_end;
    end
    if (issue) begin
      win_rd_begin <= win_begin_mem[issue_idx[IDX_W-1:0]];
      win_rd_end   <= win_end_mem[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (issue) begin
      mark_rd <= mark_mem[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      tp_total     <= '0;
      fp_total     <= '0;
      fn_total     <= '0;
      out_valid    <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issue;
      if (issue) begin
        rd_idx    <= issue_idx[IDX_W-1:0];
        rd_last   <= ((issue_idx + CNT_W'(1)) == stored_count);
        issue_idx <= issue_idx + CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (do_load) begin
            slice_hit       <= 1'b0;
            table_full      <= tbl_full_now;
            true_positives  <= tp_total;
            false_positives <= fp_total;
            false_negatives <= fn_total;
            if (tbl_full_now) begin
              windows_stored <= stored_count;
            end else begin
              stored_count   <= stored_count + CNT_W'(1);
              windows_stored <= stored_count + CNT_W'(1);
            end
          end else if (do_eot) begin
            // report the totals, then clear them
            slice_hit       <= 1'b0;
            table_full      <= 1'b0;
            true_positives  <= tp_total;
            false_positives <= fp_total;
            false_negatives <= fn_total;
            windows_stored  <= stored_count;
            tp_total        <= '0;
            fp_total        <= '0;
            fn_total        <= '0;
          end else if (start_scan) begin
            cur_op    <= head.op;
            cur_begin <= head_begin;
            cur_end   <= head_end;
            hit       <= 1'b0;
            issue_idx <= '0;
            state     <= (stored_count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (cur_op == ioroc_pkg::OP_CHECK) begin
              if (overlap) begin
                hit <= 1'b1;
              end
            end else if (!mark_rd) begin
              // unhit window adds one false positive
              fp_total <= sat_inc(fp_total);
            end
            if (rd_last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            table_full      <= 1'b0;
            false_positives <= fp_total;
            state           <= S_IDLE;
            if (cur_op == ioroc_pkg::OP_CHECK) begin
              slice_hit      <= hit;
              windows_stored <= stored_count;
              if (hit) begin
                tp_total        <= sat_inc(tp_total);
                true_positives  <= sat_inc(tp_total);
                false_negatives <= fn_total;
              end else begin
                fn_total        <= sat_inc(fn_total);
                false_negatives <= sat_inc(fn_total);
                true_positives  <= tp_total;
              end
            end else begin
              slice_hit       <= 1'b0;
              stored_count    <= '0;
              windows_stored  <= '0;
              true_positives  <= tp_total;
              false_negatives <= fn_total;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/interval_overlap_roc_counter.sv]
// interval overlap roc counter, top level; joins ioroc_front and ioroc_back, uses ioroc_pkg
// input channel in_valid/in_stall carries cmd, interval_begin, interval_end:
//   load window, check slice, end of file, end of threshold
// output channel out_valid/out_stall returns exactly one result per request
// a two-entry queue sits between the decoder and the execution engine, so the
// input side keeps taking requests while a result waits in the output register
// load and end of threshold: the request passes the queue entry, then the result register
// check slice and end of file: the scan of the single-read-port window memory reads
//   one window per cycle, then the result register is loaded
// the engine works on one request at a time; the next starts as the last finishes
// while out_stall is high the result holds and the engine waits before its next
// result; in_stall rises once the queue holds two requests
// rst clears the table fill count, the three totals and both channels
module interval_overlap_roc_counter #(
  parameter int MAX_WINDOWS = 256,
  parameter int POS_BITS    = 32,
  parameter int COUNT_BITS  = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         cmd,
  input  logic [POS_BITS-1:0]                interval_begin,
  input  logic [POS_BITS-1:0]                interval_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               slice_hit,
  output logic                               table_full,
  output logic [COUNT_BITS-1:0]              true_positives,
  output logic [COUNT_BITS-1:0]              false_positives,
  output logic [COUNT_BITS-1:0]              false_negatives,
  output logic [$clog2(MAX_WINDOWS+1)-1:0]   windows_stored
);

  ioroc_pkg::q_head_t    head;
  logic [POS_BITS-1:0]   head_begin;
  logic [POS_BITS-1:0]   head_end;
  logic                  pop;

  ioroc_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .interval_begin (interval_begin),
    .interval_end   (interval_end),
    .head           (head),
    .head_begin     (head_begin),
    .head_end       (head_end),
    .pop            (pop)
  );

  ioroc_back #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .POS_BITS    (POS_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_begin      (head_begin),
    .head_end        (head_end),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slice_hit       (slice_hit),
    .table_full      (table_full),
    .true_positives  (true_positives),
    .false_positives (false_positives),
    .false_negatives (false_negatives),
    .windows_stored  (windows_stored)
  );

endmodule

[sv/ioroc_checker.sv]
// port-level checks for interval_overlap_roc_counter, bound to the top level
// depends on interval_overlap_roc_counter_defines.svh
`include "interval_overlap_roc_counter_defines.svh"

module ioroc_checker #(
  parameter int MAX_WINDOWS = 256,
  parameter int COUNT_BITS  = 24
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               slice_hit,
  input logic                               table_full,
  input logic [COUNT_BITS-1:0]              true_positives,
  input logic [$clog2(MAX_WINDOWS+1)-1:0]   windows_stored
);

  localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

  `IOROC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(slice_hit) && $stable(true_positives) && $stable(windows_stored), "stalled result changed")

  `IOROC_ASSERT_NOW(a_hit_full_excl, out_valid, !(slice_hit && table_full), "hit and full in one result")

  `IOROC_ASSERT_NOW(a_fill_bound, out_valid, windows_stored <= CNT_W'(MAX_WINDOWS), "window count over capacity")

  `IOROC_ASSERT_NOW(a_hit_counts, out_valid && slice_hit, true_positives != '0, "hit without true positive")

  `IOROC_ASSERT_NOW(a_full_count, out_valid && table_full, windows_stored == CNT_W'(MAX_WINDOWS), "dropped load with room left")

endmodule

bind interval_overlap_roc_counter ioroc_checker #(
  .MAX_WINDOWS (MAX_WINDOWS),
  .COUNT_BITS  (COUNT_BITS)
) u_ioroc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .slice_hit      (slice_hit),
  .table_full     (table_full),
  .true_positives (true_positives),
  .windows_stored (windows_stored)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench for interval_overlap_roc_counter: directed and random requests,
// a local scoring predictor, and field-by-field checks of every result; uses ioroc_pkg
module testbench;

  localparam int MAX_WINDOWS = 256;
  localparam int POS_BITS = 32;
  localparam int COUNT_BITS = 24;
  localparam int STORED_BITS = $clog2(MAX_WINDOWS + 1);
  localparam int WIN_IDX_BITS = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int RANDOM_REQUESTS = 400;
  localparam int GAP_MAX = 17;
  localparam int HOLD_CYCLES = 300;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic                   hit;
    logic                   full;
    logic [COUNT_BITS-1:0]  tp;
    logic [COUNT_BITS-1:0]  fp;
    logic [COUNT_BITS-1:0]  fn;
    logic [STORED_BITS-1:0] stored;
  } score_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             cmd;
  pos_t                   interval_begin;
  pos_t                   interval_end;
  logic                   out_valid;
  logic                   out_stall;
  logic                   slice_hit;
  logic                   table_full;
  logic [COUNT_BITS-1:0]  true_positives;
  logic [COUNT_BITS-1:0]  false_positives;
  logic [COUNT_BITS-1:0]  false_negatives;
  logic [STORED_BITS-1:0] windows_stored;

  interval_overlap_roc_counter #(
    .MAX_WINDOWS(MAX_WINDOWS),
    .POS_BITS   (POS_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .interval_begin (interval_begin),
    .interval_end   (interval_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .slice_hit      (slice_hit),
    .table_full     (table_full),
    .true_positives (true_positives),
    .false_positives(false_positives),
    .false_negatives(false_negatives),
    .windows_stored (windows_stored)
  );

  // predictor state: window table and the three totals
  pos_t                  win_begin [MAX_WINDOWS];
  pos_t                  win_end [MAX_WINDOWS];
  logic                  win_hit [MAX_WINDOWS];
  int unsigned           win_count;
  logic [COUNT_BITS-1:0] tp_count;
  logic [COUNT_BITS-1:0] fp_count;
  logic [COUNT_BITS-1:0] fn_count;

  score_t expected_scores[$];
  int     sender_gap_max;
  int     reply_stall_max;
  int     hold_asked = 0;
  int     requests_sent;
  int     results_checked = 0;
  int     hits_seen = 0;
  int     drops_seen = 0;
  int     mismatch_count = 0;

  function automatic logic [COUNT_BITS-1:0] count_add(logic [COUNT_BITS-1:0] acc,
                                                      int unsigned inc);
    longint unsigned sum;
    sum = longint'(acc) + inc;
    return (sum > COUNT_TOP) ? COUNT_TOP : COUNT_BITS'(sum);
  endfunction

  function automatic score_t score_request(logic [1:0] op, pos_t b, pos_t e);
    score_t      s;
    int unsigned unhit;
    s = '0;
    case (op)
      ioroc_pkg::CMD_LOAD: begin
        if (win_count == MAX_WINDOWS) begin
          s.full = 1'b1;
        end else begin
          win_begin[WIN_IDX_BITS'(win_count)] = b;
          win_end[WIN_IDX_BITS'(win_count)] = e;
          win_hit[WIN_IDX_BITS'(win_count)] = 1'b0;
          win_count++;
        end
      end
      ioroc_pkg::CMD_CHECK: begin
        for (int i = 0; i < win_count; i++) begin
          if (win_begin[WIN_IDX_BITS'(i)] < e && b < win_end[WIN_IDX_BITS'(i)]) begin
            win_hit[WIN_IDX_BITS'(i)] = 1'b1;
            s.hit = 1'b1;
          end
        end
        if (s.hit) tp_count = count_add(tp_count, 1);
        else fn_count = count_add(fn_count, 1);
      end
      ioroc_pkg::CMD_END_FILE: begin
        unhit = 0;
        for (int i = 0; i < win_count; i++) begin
          if (!win_hit[WIN_IDX_BITS'(i)]) unhit++;
          win_hit[WIN_IDX_BITS'(i)] = 1'b0;
        end
        fp_count = count_add(fp_count, unhit);
        win_count = 0;
      end
      default: ;
    endcase
    s.tp = tp_count;
    s.fp = fp_count;
    s.fn = fn_count;
    s.stored = STORED_BITS'(win_count);
    // end of threshold reports the totals first, then clears them
    if (op == ioroc_pkg::CMD_END_THRESHOLD) begin
      tp_count = '0;
      fp_count = '0;
      fn_count = '0;
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one request: random gap, then hold valid until the block takes it
  task automatic send_request(input logic [1:0] op, input pos_t b, input pos_t e);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    interval_begin <= b;
    interval_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_scores.insert(expected_scores.size(), score_request(op, b, e));
    requests_sent++;
  endtask

  // sender pauses until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_scores.size() != 0) @(posedge clk);
  endtask

  function automatic void random_interval(input pos_t base, output pos_t b, output pos_t e);
    case ($urandom_range(0, 9))
      0: begin
        b = $urandom;
        e = $urandom;
      end
      1: begin
        b = base + $urandom_range(0, 300);
        e = b;
      end
      2: begin
        e = base + $urandom_range(0, 300);
        b = e + $urandom_range(1, 40);
      end
      default: begin
        b = base + $urandom_range(0, 300);
        e = b + $urandom_range(1, 60);
      end
    endcase
  endfunction

  task automatic test_empty_table();
    send_request(ioroc_pkg::CMD_CHECK, 32'd10, 32'd20);
    send_request(ioroc_pkg::CMD_END_FILE, '0, '0);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '1, '1);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '0, '1);
  endtask

  task automatic test_overlap_edges();
    send_request(ioroc_pkg::CMD_LOAD, 32'd100, 32'd200);
    send_request(ioroc_pkg::CMD_CHECK, 32'd200, 32'd300);
    send_request(ioroc_pkg::CMD_CHECK, 32'd50, 32'd100);
    send_request(ioroc_pkg::CMD_CHECK, 32'd199, 32'd200);
    send_request(ioroc_pkg::CMD_CHECK, 32'd150, 32'd150);
    send_request(ioroc_pkg::CMD_CHECK, 32'd300, 32'd50);
    send_request(ioroc_pkg::CMD_LOAD, 32'd500, 32'd500);
    send_request(ioroc_pkg::CMD_LOAD, '1, '0);
    send_request(ioroc_pkg::CMD_LOAD, 32'h8000_0000, '1);
    send_request(ioroc_pkg::CMD_CHECK, '0, '1);
    send_request(ioroc_pkg::CMD_CHECK, 32'hFFFF_FFFE, '1);
    send_request(ioroc_pkg::CMD_CHECK, '1, '1);
    send_request(ioroc_pkg::CMD_CHECK, 32'd499, 32'd501);
    send_request(ioroc_pkg::CMD_END_FILE, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(ioroc_pkg::CMD_LOAD, '0, '1);
    send_request(ioroc_pkg::CMD_LOAD, 32'd7, 32'd9);
    send_request(ioroc_pkg::CMD_CHECK, 32'd0, 32'd1);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(ioroc_pkg::CMD_END_FILE, '1, '0);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '0, '0);
  endtask

  // receiver blocks long enough for the input side to stall
  task automatic test_back_pressure();
    sender_gap_max = 0;
    hold_asked++;
    for (int i = 0; i < 4; i++)
      send_request(ioroc_pkg::CMD_LOAD, 32'(i * 100), 32'(i * 100 + 50));
    for (int i = 0; i < 6; i++)
      send_request(ioroc_pkg::CMD_CHECK, 32'(i * 70), 32'(i * 70 + 10));
    send_request(ioroc_pkg::CMD_END_FILE, '0, '0);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '0, '0);
    drain_results();
    sender_gap_max = GAP_MAX;
  endtask

  task automatic test_full_table();
    sender_gap_max = 2;
    reply_stall_max = 2;
    for (int i = 0; i < MAX_WINDOWS + 3; i++)
      send_request(ioroc_pkg::CMD_LOAD, 32'(i * 16), 32'(i * 16 + 8));
    send_request(ioroc_pkg::CMD_CHECK, 32'd0, 32'd4);
    send_request(ioroc_pkg::CMD_CHECK, 32'd4087, 32'd5000);
    send_request(ioroc_pkg::CMD_CHECK, 32'd9000, 32'd9100);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '0, '0);
    send_request(ioroc_pkg::CMD_CHECK, 32'd8, 32'd16);
    send_request(ioroc_pkg::CMD_LOAD, 32'd1, 32'd2);
    send_request(ioroc_pkg::CMD_END_FILE, '0, '0);
    send_request(ioroc_pkg::CMD_END_THRESHOLD, '0, '0);
    sender_gap_max = GAP_MAX;
    reply_stall_max = GAP_MAX;
  endtask

  // random files: loads, then slices near them, some noise, file and threshold ends
  task automatic test_random_files();
    int   first_sent;
    int   file_no;
    int   n_win;
    int   n_slice;
    pos_t base;
    pos_t b;
    pos_t e;
    first_sent = requests_sent;
    file_no = 0;
    while (requests_sent - first_sent < RANDOM_REQUESTS) begin
      file_no++;
      sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      reply_stall_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      base = $urandom;
      n_win = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      repeat (n_win) begin
        random_interval(base, b, e);
        send_request(ioroc_pkg::CMD_LOAD, b, e);
      end
      n_slice = $urandom_range(0, 10);
      repeat (n_slice) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(2'($urandom_range(0, 3)), $urandom, $urandom);
        end else begin
          random_interval(base, b, e);
          send_request(ioroc_pkg::CMD_CHECK, b, e);
        end
      end
      if ($urandom_range(0, 7) != 0)
        send_request(ioroc_pkg::CMD_END_FILE, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0)
        send_request(ioroc_pkg::CMD_END_THRESHOLD, $urandom, $urandom);
      if (file_no % 8 == 0) drain_results();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver pacing: a random stall after each result, plus long hold-offs on request
  initial begin : reply_pacing
    int hold_left;
    int wait_left;
    int hold_taken;
    hold_left = 0;
    wait_left = 0;
    hold_taken = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (!rst && out_valid && !out_stall) wait_left = $urandom_range(0, reply_stall_max);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    score_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("result with no request pending", '0, '0);
      end else begin
        want = expected_scores.pop_front();
        results_checked++;
        if (slice_hit) hits_seen++;
        if (table_full) drops_seen++;
        if (slice_hit !== want.hit)
          report_mismatch("slice_hit", 32'(slice_hit), 32'(want.hit));
        if (table_full !== want.full)
          report_mismatch("table_full", 32'(table_full), 32'(want.full));
        if (true_positives !== want.tp)
          report_mismatch("true_positives", 32'(true_positives), 32'(want.tp));
        if (false_positives !== want.fp)
          report_mismatch("false_positives", 32'(false_positives), 32'(want.fp));
        if (false_negatives !== want.fn)
          report_mismatch("false_negatives", 32'(false_negatives), 32'(want.fn));
        if (windows_stored !== want.stored)
          report_mismatch("windows_stored", 32'(windows_stored), 32'(want.stored));
      end
    end
  end

  initial begin
    #15_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = ioroc_pkg::CMD_LOAD;
    interval_begin = '0;
    interval_end = '0;
    sender_gap_max = GAP_MAX;
    reply_stall_max = GAP_MAX;
    requests_sent = 0;
    win_count = 0;
    tp_count = '0;
    fp_count = '0;
    fn_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_overlap_edges();
    test_back_pressure();
    test_full_table();
    test_random_files();

    drain_results();
    repeat (MAX_WINDOWS + 16) @(posedge clk);
    $display("sent %0d requests (loads, slices, file and threshold ends), checked %0d results",
             requests_sent, results_checked);
    $display("saw %0d slice hits and %0d dropped loads, %0d mismatches",
             hits_seen, drops_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
